@@ hdl/sorted_priority_queue_defines.svh @@
// Assertion macros for the sorted priority queue.
// Included by files that carry concurrent assertions; needs nothing else.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("spq assertion failed");

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("spq assertion failed");

`endif

@@ hdl/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
// No dependencies; used by the interfaces and all modules.
package spq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    localparam int OP_W    = 2;
    localparam int VAL_W   = 32;
    localparam int PRI_W   = 16;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_REM_HEAD = 2'd1,
        OP_REM_TAIL = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_cmd;

endpackage

@@ hdl/spq_req_if.sv @@
// Request channel of the sorted priority queue: valid/ready plus one operation.
// Depends on spq_pkg for field widths.
interface spq_req_if;
    logic                             valid;
    logic                             ready;
    logic [spq_pkg::OP_W-1:0]         operation;
    logic signed [spq_pkg::VAL_W-1:0] value;
    logic [spq_pkg::PRI_W-1:0]        priority_req;

    modport source (output valid, output operation, output value, output priority_req,
                    input ready);
    modport sink   (input valid, input operation, input value, input priority_req,
                    output ready);
endinterface

@@ hdl/spq_rsp_if.sv @@
// Response channel of the sorted priority queue: valid/ready plus one result.
// Depends on spq_pkg for field widths.
interface spq_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [spq_pkg::STAT_W-1:0]       status;
    logic signed [spq_pkg::VAL_W-1:0] head_value;
    logic [spq_pkg::PRI_W-1:0]        head_priority;
    logic                             head_valid;
    logic [spq_pkg::COUNT_W-1:0]      count;

    modport source (output valid, output status, output head_value, output head_priority,
                    output head_valid, output count, input ready);
    modport sink   (input valid, input status, input head_value, input head_priority,
                    input head_valid, input count, output ready);
endinterface

@@ hdl/spq_ctrl.sv @@
// Controller of the sorted priority queue: capture/execute sequencing and
// result-valid tracking. Depends on spq_pkg.
module spq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output spq_pkg::t_cmd  o_cmd
);

    spq_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            spq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = spq_pkg::S_EXEC;
                end
            end
            spq_pkg::S_EXEC: begin
                if (out_free) begin
                    n_state = spq_pkg::S_IDLE;
                end
            end
            default: n_state = spq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            spq_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            spq_pkg::S_EXEC: begin
                o_cmd.execute = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.execute) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ hdl/spq_dpath.sv @@
// Datapath of the sorted priority queue: operand capture, sorted shifting
// cell chain, capacity register and result register. Depends on spq_pkg.
module spq_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  spq_pkg::t_cmd                    i_cmd,
    input  logic                             i_cfg_we,
    input  logic [spq_pkg::CAP_W-1:0]        i_cfg_wdata,
    input  logic [spq_pkg::OP_W-1:0]         i_operation,
    input  logic signed [spq_pkg::VAL_W-1:0] i_value,
    input  logic [spq_pkg::PRI_W-1:0]        i_priority_req,
    output logic [spq_pkg::STAT_W-1:0]       o_status,
    output logic signed [spq_pkg::VAL_W-1:0] o_head_value,
    output logic [spq_pkg::PRI_W-1:0]        o_head_priority,
    output logic                             o_head_valid,
    output logic [spq_pkg::COUNT_W-1:0]      o_count
);

    localparam int D = spq_pkg::DEPTH;

    spq_pkg::t_op                     r_op;
    logic signed [spq_pkg::VAL_W-1:0] r_value;
    logic [spq_pkg::PRI_W-1:0]        r_prio;
    logic [spq_pkg::CAP_W-1:0]        r_cap;
    logic [spq_pkg::CNT_W-1:0]        r_count, n_count;

    logic signed [spq_pkg::VAL_W-1:0] r_val [D];
    logic [spq_pkg::PRI_W-1:0]        r_pri [D];
    logic signed [spq_pkg::VAL_W-1:0] n_val [D];
    logic [spq_pkg::PRI_W-1:0]        n_pri [D];
    logic signed [spq_pkg::VAL_W-1:0] sh_val [D];
    logic [spq_pkg::PRI_W-1:0]        sh_pri [D];
    logic signed [spq_pkg::VAL_W-1:0] up_val [D];
    logic [spq_pkg::PRI_W-1:0]        up_pri [D];

    logic [D-1:0]                     gt;
    logic [D-1:0]                     gt_prev;
    logic                             full;
    logic                             empty;
    spq_pkg::t_status                 n_status;

    logic [spq_pkg::STAT_W-1:0]       r_o_status;
    logic signed [spq_pkg::VAL_W-1:0] r_o_hval;
    logic [spq_pkg::PRI_W-1:0]        r_o_hpri;
    logic                             r_o_hvld;
    logic [spq_pkg::COUNT_W-1:0]      r_o_cnt;

    assign full  = (spq_pkg::CMP_W'(r_count) >= spq_pkg::CMP_W'(r_cap)) ||
                   (r_count >= spq_pkg::CNT_W'(D));
    assign empty = (r_count == '0);

    // cells strictly ahead of the insert point form a prefix
    always_comb begin
        for (int i = 0; i < D; i++) begin
            gt[i] = (spq_pkg::CNT_W'(i) < r_count) && (r_pri[i] > r_prio);
        end
        gt_prev = {gt[D-2:0], 1'b1};
    end

    always_comb begin
        sh_val[0] = r_value;
        sh_pri[0] = r_prio;
        for (int i = 1; i < D; i++) begin
            sh_val[i] = r_val[i-1];
            sh_pri[i] = r_pri[i-1];
        end
        for (int i = 0; i < D - 1; i++) begin
            up_val[i] = r_val[i+1];
            up_pri[i] = r_pri[i+1];
        end
        up_val[D-1] = r_val[D-1];
        up_pri[D-1] = r_pri[D-1];
    end

    always_comb begin
        n_val    = r_val;
        n_pri    = r_pri;
        n_count  = r_count;
        n_status = spq_pkg::STAT_DONE;
        case (r_op)
            spq_pkg::OP_INSERT: begin
                if (full) begin
                    n_status = spq_pkg::STAT_FULL;
                end else begin
                    for (int i = 0; i < D; i++) begin
                        if (gt[i]) begin
                            n_val[i] = r_val[i];
                            n_pri[i] = r_pri[i];
                        end else if (gt_prev[i]) begin
                            n_val[i] = r_value;
                            n_pri[i] = r_prio;
                        end else begin
                            n_val[i] = sh_val[i];
                            n_pri[i] = sh_pri[i];
                        end
                    end
                    n_count = r_count + spq_pkg::CNT_W'(1);
                end
            end
            spq_pkg::OP_REM_HEAD: begin
                if (empty) begin
                    n_status = spq_pkg::STAT_EMPTY;
                end else begin
                    n_val   = up_val;
                    n_pri   = up_pri;
                    n_count = r_count - spq_pkg::CNT_W'(1);
                end
            end
            spq_pkg::OP_REM_TAIL: begin
                if (empty) begin
                    n_status = spq_pkg::STAT_EMPTY;
                end else begin
                    n_count = r_count - spq_pkg::CNT_W'(1);
                end
            end
            spq_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= spq_pkg::t_op'(i_operation);
            r_value <= i_value;
            r_prio  <= i_priority_req;
        end
        if (i_cmd.execute) begin
            r_val      <= n_val;
            r_pri      <= n_pri;
            r_o_status <= n_status;
            r_o_cnt    <= spq_pkg::COUNT_W'(n_count);
            r_o_hvld   <= (n_count != '0);
            r_o_hval   <= (n_count != '0) ? n_val[0] : '0;
            r_o_hpri   <= (n_count != '0) ? n_pri[0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= spq_pkg::CAP_RESET;
        end else begin
            if (i_cmd.execute) begin
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    assign o_status        = r_o_status;
    assign o_head_value    = r_o_hval;
    assign o_head_priority = r_o_hpri;
    assign o_head_valid    = r_o_hvld;
    assign o_count         = r_o_cnt;

endmodule

@@ hdl/sorted_priority_queue.sv @@
// Sorted priority queue: a bounded queue of (value, priority) entries kept in
// descending priority order in a chain of shifting cells, one per entry. Each
// request beat is one operation (insert, remove head, remove tail, clear) and
// gives exactly one response beat with the status, the head entry after the
// operation and the entry count. The beat is captured in the cycle it is
// accepted; the execute state waits for a free response register, then
// updates the cell chain in one step and loads the response register. The
// next request beat is taken in the cycle after that update; a response
// still waiting to be taken does not block capture of the next request,
// only its update step. An insert is rejected as full when the count
// reaches the capacity register or the number of cells. The user must write
// capacity through i_cfg_we and i_cfg_wdata only while the queue is idle;
// the block does not enforce this. No clearing pass follows reset.
// Depends on spq_pkg, spq_req_if, spq_rsp_if, spq_ctrl, spq_dpath.
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    spq_req_if.sink                   i_req,
    spq_rsp_if.source                 o_rsp,
    input  logic                      i_cfg_we,
    input  logic [spq_pkg::CAP_W-1:0] i_cfg_wdata
);

    spq_pkg::t_cmd s_cmd;
    logic          s_in_ready;
    logic          s_out_valid;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (s_in_ready),
        .o_out_valid (s_out_valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (s_cmd)
    );

    spq_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (s_cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_operation     (i_req.operation),
        .i_value         (i_req.value),
        .i_priority_req  (i_req.priority_req),
        .o_status        (o_rsp.status),
        .o_head_value    (o_rsp.head_value),
        .o_head_priority (o_rsp.head_priority),
        .o_head_valid    (o_rsp.head_valid),
        .o_count         (o_rsp.count)
    );

    assign i_req.ready = s_in_ready;
    assign o_rsp.valid = s_out_valid;

    `SPQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, o_rsp.valid, o_rsp.count <= spq_pkg::COUNT_W'(spq_pkg::DEPTH))
    `SPQ_ASSERT_NOW(a_head_valid, i_clk, i_rst_n, o_rsp.valid, o_rsp.head_valid == (o_rsp.count != '0))
    `SPQ_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready)
    `SPQ_ASSERT_NEXT(a_result_after_exec, i_clk, i_rst_n, s_cmd.execute, o_rsp.valid)

endmodule

@@ tb/sorted_priority_queue_tb.sv @@
`timescale 1ns / 100ps
// Testbench for sorted_priority_queue: directed and random operation beats
// checked against an in-bench model of the ordered queue and its capacity.
// Depends on spq_pkg, spq_req_if, spq_rsp_if and the sorted_priority_queue RTL.
module sorted_priority_queue_tb;

    typedef struct {
        spq_pkg::t_status                   status;
        logic [spq_pkg::VAL_W-1:0]          head_value;
        logic [spq_pkg::PRI_W-1:0]          head_priority;
        logic                               head_valid;
        logic [spq_pkg::COUNT_W-1:0]        count;
    } t_result;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [spq_pkg::CAP_W-1:0] i_cfg_wdata;

    spq_req_if req_if ();
    spq_rsp_if rsp_if ();

    sorted_priority_queue u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // queue model
    logic [spq_pkg::VAL_W-1:0] held_values [spq_pkg::DEPTH];
    logic [spq_pkg::PRI_W-1:0] held_prios  [spq_pkg::DEPTH];
    int                        held_count;
    int                        cap_limit;

    t_result pending_results [$];
    int      error_count;
    bit      no_idle;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #5_000_000;
        $display("sorted_priority_queue_tb failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    task automatic predict_op(input spq_pkg::t_op op, input logic [spq_pkg::VAL_W-1:0] v,
                              input logic [spq_pkg::PRI_W-1:0] p);
        t_result r;
        int      pos;
        int      i;
        r.status = spq_pkg::STAT_DONE;
        case (op)
            spq_pkg::OP_INSERT: begin
                if (held_count >= cap_limit || held_count >= spq_pkg::DEPTH) begin
                    r.status = spq_pkg::STAT_FULL;
                end else begin
                    pos = 0;
                    while (pos < held_count && held_prios[pos] > p) begin
                        pos++;
                    end
                    for (i = held_count; i > pos; i--) begin
                        held_values[i] = held_values[i-1];
                        held_prios[i]  = held_prios[i-1];
                    end
                    held_values[pos] = v;
                    held_prios[pos]  = p;
                    held_count++;
                end
            end
            spq_pkg::OP_REM_HEAD: begin
                if (held_count == 0) begin
                    r.status = spq_pkg::STAT_EMPTY;
                end else begin
                    for (i = 1; i < held_count; i++) begin
                        held_values[i-1] = held_values[i];
                        held_prios[i-1]  = held_prios[i];
                    end
                    held_count--;
                end
            end
            spq_pkg::OP_REM_TAIL: begin
                if (held_count == 0) begin
                    r.status = spq_pkg::STAT_EMPTY;
                end else begin
                    held_count--;
                end
            end
            default: begin
                held_count = 0;
            end
        endcase
        r.head_valid    = (held_count > 0);
        r.head_value    = r.head_valid ? held_values[0] : '0;
        r.head_priority = r.head_valid ? held_prios[0] : '0;
        r.count         = spq_pkg::COUNT_W'(held_count);
        pending_results.push_back(r);
    endtask

    task automatic send_op(input spq_pkg::t_op op, input logic [spq_pkg::VAL_W-1:0] v,
                           input logic [spq_pkg::PRI_W-1:0] p);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.operation    <= op;
        req_if.value        <= v;
        req_if.priority_req <= p;
        do @(posedge i_clk); while (!req_if.ready);
        predict_op(op, v, p);
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [spq_pkg::CAP_W-1:0] c);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= c;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cap_limit = c;
    endtask

    function automatic spq_pkg::t_op rand_op(input int ins_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_pct) begin
            return spq_pkg::OP_INSERT;
        end
        if (r >= 97) begin
            return spq_pkg::OP_CLEAR;
        end
        return r[0] ? spq_pkg::OP_REM_HEAD : spq_pkg::OP_REM_TAIL;
    endfunction

    function automatic logic [spq_pkg::PRI_W-1:0] rand_prio();
        case ($urandom_range(0, 3))
            0: return spq_pkg::PRI_W'($urandom_range(0, 3));
            1: begin
                case ($urandom_range(0, 3))
                    0: return 16'h0000;
                    1: return 16'hFFFF;
                    2: return 16'h8000;
                    default: return 16'h7FFF;
                endcase
            end
            default: return spq_pkg::PRI_W'($urandom);
        endcase
    endfunction

    // response checker
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            check_result();
        end
    end

    task automatic check_result();
        t_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("beat with nothing pending, count", 32'(rsp_if.count), 32'hx);
        end else begin
            want = pending_results.pop_front();
            check_field("status", 32'(rsp_if.status), 32'(want.status));
            check_field("head_value", rsp_if.head_value, want.head_value);
            check_field("head_priority", 32'(rsp_if.head_priority), 32'(want.head_priority));
            check_field("head_valid", 32'(rsp_if.head_valid), 32'(want.head_valid));
            check_field("count", 32'(rsp_if.count), 32'(want.count));
        end
    endtask

    initial begin : rsp_ready_gen
        int stall;
        stall = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (no_idle) begin
                rsp_if.ready <= 1'b1;
            end else if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                stall--;
            end else begin
                rsp_if.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    task automatic test_empty_queue();
        send_op(spq_pkg::OP_REM_HEAD, 32'h7FFF_FFFF, 16'hFFFF);
        send_op(spq_pkg::OP_REM_TAIL, 32'h8000_0000, 16'h0000);
        send_op(spq_pkg::OP_CLEAR, $urandom, spq_pkg::PRI_W'($urandom));
    endtask

    task automatic test_capacity_limits();
        set_capacity(0);
        send_op(spq_pkg::OP_INSERT, 32'h1234_5678, 16'h0001);
        set_capacity(2);
        send_op(spq_pkg::OP_INSERT, 32'h7FFF_FFFF, 16'hFFFF);
        send_op(spq_pkg::OP_INSERT, 32'h8000_0000, 16'h0000);
        send_op(spq_pkg::OP_INSERT, 32'h0000_0000, 16'h8000);
        // capacity below current count
        set_capacity(1);
        send_op(spq_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'h1234);
        send_op(spq_pkg::OP_REM_TAIL, 32'h0, 16'h0);
        send_op(spq_pkg::OP_INSERT, 32'h5555_AAAA, 16'hAAAA);
        send_op(spq_pkg::OP_REM_HEAD, 32'h0, 16'h0);
    endtask

    task automatic test_ordering();
        set_capacity(16);
        send_op(spq_pkg::OP_INSERT, 32'd10, 16'h8000);
        send_op(spq_pkg::OP_INSERT, 32'd20, 16'h8000);
        send_op(spq_pkg::OP_INSERT, 32'd30, 16'h7FFF);
        send_op(spq_pkg::OP_INSERT, 32'd40, 16'hFFFF);
        send_op(spq_pkg::OP_INSERT, 32'd50, 16'h0000);
        send_op(spq_pkg::OP_REM_HEAD, 32'h0, 16'h0);
        send_op(spq_pkg::OP_REM_TAIL, 32'h0, 16'h0);
        send_op(spq_pkg::OP_REM_TAIL, 32'h0, 16'h0);
        send_op(spq_pkg::OP_REM_HEAD, 32'h0, 16'h0);
        // single entry left, tail removal empties the queue
        send_op(spq_pkg::OP_REM_TAIL, 32'h0, 16'h0);
        send_op(spq_pkg::OP_INSERT, 32'd60, 16'd5);
        send_op(spq_pkg::OP_INSERT, 32'd70, 16'd5);
        send_op(spq_pkg::OP_CLEAR, 32'h0, 16'h0);
    endtask

    task automatic test_random_mix();
        int caps    [7] = '{16, 31, 3, 0, 17, 1, 0};
        int beats   [7] = '{120, 120, 90, 30, 120, 60, 110};
        int ins_pct [7] = '{70, 75, 55, 60, 65, 50, 60};
        int ph;
        int n;
        caps[6] = $urandom_range(0, 31);
        for (ph = 0; ph < 7; ph++) begin
            set_capacity(spq_pkg::CAP_W'(caps[ph]));
            no_idle = (ph == 4);
            for (n = 0; n < beats[ph]; n++) begin
                if (ph == 0 && n == 60) begin
                    wait_idle();
                end
                send_op(rand_op(ins_pct[ph]), $urandom, rand_prio());
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        error_count = 0;
        no_idle     = 1'b0;
        held_count  = 0;
        cap_limit   = 16;
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_wdata         <= '0;
        req_if.valid        <= 1'b0;
        req_if.operation    <= spq_pkg::OP_INSERT;
        req_if.value        <= '0;
        req_if.priority_req <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_capacity_limits();
        test_ordering();
        test_random_mix();

        wait_idle();
        if (error_count == 0) begin
            $display("sorted_priority_queue_tb passed");
        end else begin
            $display("sorted_priority_queue_tb failed");
        end
        $finish;
    end

endmodule
